// File: design/pfhp_pkg.sv
package pfhp_pkg;

	localparam logic [7:0]  SYNC_P      = 8'h50;
	localparam logic [7:0]  SYNC_F      = 8'h46;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [15:0] CRC_RESIDUE = 16'h1D0F;
	localparam logic [14:0] POS_MAX     = 15'h7FFF;
	localparam logic [4:0]  MIN_HDR     = 5'd14;

	typedef enum logic [2:0] {
		ST_PAYLOAD    = 3'd0,
		ST_OK         = 3'd1,
		ST_SHORT      = 3'd2,
		ST_BAD_SYNC   = 3'd3,
		ST_INCOMPLETE = 3'd4,
		ST_CRC_ERR    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_PAYLOAD = 3'b010,
		PH_DONE    = 3'b100
	} phase_t;

	typedef struct packed {
		logic [15:0] pseq;
		logic [23:0] findex;
		logic [23:0] fcount;
		logic        fec_flag;
		logic        addr_flag;
		logic [13:0] plen;
		logic [7:0]  rs_k;
		logic [7:0]  rs_z;
		logic [15:0] source_addr;
		logic [15:0] dest_addr;
	} hdr_fields_t;

	// one queue record: an optional payload beat followed by an optional summary beat
	typedef struct packed {
		logic        pay_v;
		logic [7:0]  pay_byte;
		logic        sum_v;
		status_t     sum_status;
		hdr_fields_t fields;
	} rec_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [4:0] hdr_len(input logic fec, input logic addr);
		return MIN_HDR + (fec ? 5'd2 : 5'd0) + (addr ? 5'd4 : 5'd0);
	endfunction

endpackage

// File: design/pft_fragment_header_parser_core.sv
// PFT fragment header parser. Push one fragment byte per cycle with last_byte on the final
// byte; the parser never holds input for internal work, so full only rises when DEPTH
// records are waiting in the result queue. A byte is parsed in the cycle it is pushed and
// its results can be popped from the next cycle on. A byte yields at most two beats (a
// payload beat then a summary beat) kept as one queue record; the result side pops one beat
// per cycle, so a byte that yields two beats takes two pops. Payload beats carry status 0
// and zero header fields; the summary beat carries the status and the header fields.
module pft_fragment_header_parser_core
	import pfhp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [7:0]  payload_byte,
	output logic [15:0] pseq,
	output logic [23:0] findex,
	output logic [23:0] fcount,
	output logic        fec_flag,
	output logic        addr_flag,
	output logic [13:0] plen,
	output logic [7:0]  rs_k,
	output logic [7:0]  rs_z,
	output logic [15:0] source_addr,
	output logic [15:0] dest_addr
);

	logic        rec_v;
	rec_t        rec_in, cur;
	logic        q_empty, q_full, q_rd;
	logic        half_q;
	logic        show_pay, pop_acc;
	hdr_fields_t f;

	pfhp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.q_full    (q_full),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.rec_v     (rec_v),
		.rec       (rec_in)
	);

	pfhp_fifo #(.DEPTH(DEPTH)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_v),
		.wr_data (rec_in),
		.rd_en   (q_rd),
		.rd_data (cur),
		.empty   (q_empty),
		.full    (q_full)
	);

	assign full  = q_full;
	assign empty = q_empty;

	// half_q marks that the payload beat of a two-beat record is already gone
	assign show_pay = cur.pay_v && !half_q;
	assign pop_acc  = pop && !q_empty;
	assign q_rd     = pop_acc && !(cur.pay_v && cur.sum_v && !half_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 1'b0;
		end else if (pop_acc) begin
			half_q <= !q_rd;
		end
	end

	assign f            = show_pay ? '0 : cur.fields;
	assign status       = show_pay ? 3'(ST_PAYLOAD) : 3'(cur.sum_status);
	assign payload_byte = show_pay ? cur.pay_byte : 8'h00;
	assign pseq         = f.pseq;
	assign findex       = f.findex;
	assign fcount       = f.fcount;
	assign fec_flag     = f.fec_flag;
	assign addr_flag    = f.addr_flag;
	assign plen         = f.plen;
	assign rs_k         = f.rs_k;
	assign rs_z         = f.rs_z;
	assign source_addr  = f.source_addr;
	assign dest_addr    = f.dest_addr;

endmodule

// File: design/pfhp_front.sv
module pfhp_front
	import pfhp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       q_full,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       rec_v,
	output rec_t       rec
);

	logic [14:0] pos_q, pos_n;
	phase_t      phase_q, phase_n;
	logic        sync_q, sync_n;
	logic [15:0] crc_q, crc_n;
	hdr_fields_t hdr_q, hdr_n;
	logic        sent_q, sent_n;

	logic        accept;
	logic [4:0]  hlen;
	logic [14:0] off, off2;
	logic [15:0] pay_cnt;
	logic        good;

	assign accept = push && !q_full;

	always_comb begin
		pos_n   = pos_q;
		phase_n = phase_q;
		sync_n  = sync_q;
		crc_n   = crc_q;
		hdr_n   = hdr_q;
		sent_n  = sent_q;
		rec     = '0;
		off     = pos_q - 15'd12;
		off2    = off - 15'd2;
		hlen    = hdr_len(hdr_q.fec_flag, hdr_q.addr_flag);
		pay_cnt = {1'b0, pos_q} + 16'd1 - {11'b0, hlen};
		good    = !hdr_q.fec_flag || (crc_q == CRC_RESIDUE);

		if (!sent_q) begin
			case (phase_q)
				PH_HEADER: begin
					crc_n = crc_feed(crc_q, data_byte);
					if (pos_q == 15'd0 && data_byte != SYNC_P) begin
						sync_n = 1'b0;
					end
					if (pos_q == 15'd1 && data_byte != SYNC_F) begin
						sync_n = 1'b0;
					end
					if (sync_n) begin
						if (pos_q == 15'd2 || pos_q == 15'd3) begin
							hdr_n.pseq = {hdr_q.pseq[7:0], data_byte};
						end else if (pos_q >= 15'd4 && pos_q <= 15'd6) begin
							hdr_n.findex = {hdr_q.findex[15:0], data_byte};
						end else if (pos_q >= 15'd7 && pos_q <= 15'd9) begin
							hdr_n.fcount = {hdr_q.fcount[15:0], data_byte};
						end else if (pos_q == 15'd10) begin
							hdr_n.fec_flag  = data_byte[7];
							hdr_n.addr_flag = data_byte[6];
							hdr_n.plen      = {data_byte[5:0], 8'h00};
						end else if (pos_q == 15'd11) begin
							hdr_n.plen = {hdr_q.plen[13:8], data_byte};
						end else if (pos_q >= 15'd12) begin
							if (hdr_q.fec_flag && off < 15'd2) begin
								hdr_n.rs_k = hdr_q.rs_z;
								hdr_n.rs_z = data_byte;
							end else if (hdr_q.addr_flag
								&& ((hdr_q.fec_flag && off2 < 15'd4)
								|| (!hdr_q.fec_flag && off < 15'd4))) begin
								hdr_n.source_addr = {hdr_q.source_addr[7:0], hdr_q.dest_addr[15:8]};
								hdr_n.dest_addr   = {hdr_q.dest_addr[7:0], data_byte};
							end
						end
						// flags are settled by now, so hlen from the held flags is final
						if (pos_q >= 15'd12 && pos_q == {10'b0, hlen} - 15'd1) begin
							if (hdr_n.plen == 14'd0) begin
								rec.sum_v      = 1'b1;
								rec.sum_status = (!hdr_n.fec_flag || crc_n == CRC_RESIDUE)
									? ST_OK : ST_CRC_ERR;
								rec.fields     = hdr_n;
								sent_n         = 1'b1;
								phase_n        = PH_DONE;
							end else begin
								phase_n = PH_PAYLOAD;
							end
						end
					end
				end
				PH_PAYLOAD: begin
					if (good) begin
						rec.pay_v    = 1'b1;
						rec.pay_byte = data_byte;
					end
					if (pay_cnt >= {2'b0, hdr_q.plen}) begin
						rec.sum_v      = 1'b1;
						rec.sum_status = good ? ST_OK : ST_CRC_ERR;
						rec.fields     = hdr_q;
						sent_n         = 1'b1;
						phase_n        = PH_DONE;
					end
				end
				default: ;
			endcase
		end

		if (last_byte) begin
			if (!sent_n) begin
				rec.sum_v = 1'b1;
				if (pos_q < 15'd13) begin
					rec.sum_status = ST_SHORT;
				end else if (!sync_n) begin
					rec.sum_status = ST_BAD_SYNC;
				end else begin
					rec.sum_status = ST_INCOMPLETE;
					rec.fields     = hdr_n;
				end
			end
			pos_n   = '0;
			phase_n = PH_HEADER;
			sync_n  = 1'b1;
			crc_n   = CRC_INIT;
			hdr_n   = '0;
			sent_n  = 1'b0;
		end else if (pos_q != POS_MAX) begin
			pos_n = pos_q + 15'd1;
		end
	end

	assign rec_v = accept && (rec.pay_v || rec.sum_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_HEADER;
			sync_q  <= 1'b1;
			crc_q   <= CRC_INIT;
			hdr_q   <= '0;
			sent_q  <= 1'b0;
		end else if (accept) begin
			pos_q   <= pos_n;
			phase_q <= phase_n;
			sync_q  <= sync_n;
			crc_q   <= crc_n;
			hdr_q   <= hdr_n;
			sent_q  <= sent_n;
		end
	end

endmodule

// File: design/pfhp_fifo.sv
module pfhp_fifo
	import pfhp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  rec_t wr_data,
	input  logic rd_en,
	output rec_t rd_data,
	output logic empty,
	output logic full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	rec_t          mem_q [DEPTH];
	rec_t          rd_q;
	logic [PW-1:0] head_q, tail_q, head_nxt;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign empty    = (count_q == '0);
	assign full     = (count_q == FULL_CNT);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && !empty;
	assign head_nxt = do_rd ? ((head_q == LAST_PTR) ? '0 : head_q + PW'(1)) : head_q;
	assign rd_data  = rd_q;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[tail_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			rd_q    <= '0;
		end else begin
			if (do_wr) begin
				tail_q <= (tail_q == LAST_PTR) ? '0 : tail_q + PW'(1);
			end
			head_q <= head_nxt;
			// the head register follows the oldest entry, bypassing a write into that slot
			if (do_wr && tail_q == head_nxt) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem_q[head_nxt];
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: ;
			endcase
		end
	end

endmodule
